// ----- src/rvx_pkg.sv -----
// ----------------------------------------------------------------------------
// rvx_pkg
// Shared codes for the RV64IM execute core: opcodes, status, memory requests
// ----------------------------------------------------------------------------
`default_nettype none

package rvx_pkg;

    localparam int XLEN = 64;

    // reset values of the configuration registers
    localparam logic [63:0] START_PC_RST  = 64'd4096;
    localparam logic [63:0] STACK_TOP_RST = 64'd65536;

    // configuration register indexes
    localparam logic CFG_START_PC  = 1'b0;
    localparam logic CFG_STACK_TOP = 1'b1;

    // item kinds on the input side
    localparam logic [1:0] REQ_INSTR   = 2'd0;
    localparam logic [1:0] REQ_LOAD    = 2'd1;
    localparam logic [1:0] REQ_SYSCALL = 2'd2;

    // result status
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_AW_LOAD  = 3'd1;
    localparam logic [2:0] ST_AW_SYS   = 3'd2;
    localparam logic [2:0] ST_EBREAK   = 3'd3;
    localparam logic [2:0] ST_ILLEGAL  = 3'd4;

    // memory request codes
    localparam logic [1:0] MEM_NONE  = 2'd0;
    localparam logic [1:0] MEM_READ  = 2'd1;
    localparam logic [1:0] MEM_WRITE = 2'd2;

    // wait modes
    localparam logic [1:0] WAIT_NONE = 2'd0;
    localparam logic [1:0] WAIT_LOAD = 2'd1;
    localparam logic [1:0] WAIT_SYS  = 2'd2;

    // major opcodes
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_FENCE  = 7'h0F;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_AUIPC  = 7'h17;
    localparam logic [6:0] OP_IMM32  = 7'h1B;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_REG    = 7'h33;
    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_REG32  = 7'h3B;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_JALR   = 7'h67;
    localparam logic [6:0] OP_JAL    = 7'h6F;
    localparam logic [6:0] OP_SYSTEM = 7'h73;

    // funct7 values
    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_MULDIV = 7'h01;
    localparam logic [6:0] F7_ALT  = 7'h20;

    // register numbers with fixed roles
    localparam logic [4:0] REG_SP  = 5'd2;
    localparam logic [4:0] REG_A0  = 5'd10;
    localparam logic [4:0] REG_A7  = 5'd17;

    function automatic logic [63:0] sx32(input logic [63:0] v);
        return {{32{v[31]}}, v[31:0]};
    endfunction

endpackage

`default_nettype wire

// ----- src/rv64im_execute_core.sv -----
// ----------------------------------------------------------------------------
// rv64im_execute_core
// Multi-cycle RV64IM execute core with register file, pc, and an iterative
// multiply / divide unit; memory and syscalls are served outside
// ----------------------------------------------------------------------------
//  channel   | dir | handshake          | payload
//  s_*       | in  | s_tvalid/s_tready  | tuser req_type, tdata instr/return data
//  m_*       | out | m_tvalid/m_tready  | tuser status, tdata pc/mem/syscall
//  cfg_*     | in  | cfg_wr_en          | cfg_index, cfg_wr_data
//
//  an item passes accept, operand read, execute and result in that order; the
//  operand read step is there for the registered read of the register file
//  mul/div items add a loop after execute: the add/subtract step runs one
//  bit per cycle over 64 steps, then a fixup step before the result
//  s_tready is high only in idle; one finished beat may wait in the output
//  register while the next item is worked on
//  reset is asynchronous, active low; the register file needs no clearing
// ----------------------------------------------------------------------------
`default_nettype none

module rv64im_execute_core
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    // s_tdata: instr_word[31:0], return_data[95:32]
    input  wire logic [95:0]  s_tdata,
    // s_tuser: req_type[1:0]
    input  wire logic [1:0]   s_tuser,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // m_tdata: fetch_pc[63:0], mem_request[65:64], mem_address[129:66],
    //          mem_size[131:130], mem_store_data[195:132], syscall_code[259:196]
    output logic [263:0]      m_tdata,
    // m_tuser: status[2:0]
    output logic [2:0]        m_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    input  wire logic         cfg_wr_en,
    input  wire logic         cfg_index,
    input  wire logic [63:0]  cfg_wr_data
);

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_EXEC, S_MD, S_MDFIN, S_DONE
    } state_t;

    state_t state_reg;

    // architectural state
    logic [63:0] start_pc_reg, stack_top_reg, pc_reg;
    logic [63:0] rf_mem [32];
    logic [31:0] rf_valid_reg;
    logic [4:0]  pend_dest_reg;
    logic [2:0]  pend_kind_reg;
    logic [1:0]  wait_reg;
    logic        stopped_reg, stop_cause_reg;

    // latched item
    logic [1:0]  rt_reg;
    logic [31:0] inst_reg;
    logic [63:0] ret_reg;

    // operand read
    logic [63:0] rda_reg, rdb_reg;
    logic        va_reg, vb_reg;
    logic [4:0]  ia_reg, ib_reg;

    // result held until the output slot is free
    logic [2:0]  res_status_reg;
    logic [1:0]  res_req_reg, res_size_reg;
    logic [63:0] res_addr_reg, res_sdata_reg, res_sys_reg;

    // output register
    logic        out_valid_reg;
    logic [2:0]  out_status_reg;
    logic [1:0]  out_req_reg, out_size_reg;
    logic [63:0] out_pc_reg, out_addr_reg, out_sdata_reg, out_sys_reg;

    // mul/div unit
    logic [63:0] hi_reg, lo_reg, opa_reg, opb_reg, mb_reg;
    logic [5:0]  cnt_reg;
    logic [2:0]  md_f3_reg;
    logic        md_word_reg;
    logic [4:0]  md_rd_reg;

    // instruction fields
    logic [6:0]  op, f7;
    logic [4:0]  rd, rs1, rs2;
    logic [2:0]  f3;
    logic [63:0] immi, imms, immb, immj, immu;

    assign op   = inst_reg[6:0];
    assign rd   = inst_reg[11:7];
    assign f3   = inst_reg[14:12];
    assign rs1  = inst_reg[19:15];
    assign rs2  = inst_reg[24:20];
    assign f7   = inst_reg[31:25];
    assign immi = {{52{inst_reg[31]}}, inst_reg[31:20]};
    assign imms = {{52{inst_reg[31]}}, inst_reg[31:25], inst_reg[11:7]};
    assign immb = {{51{inst_reg[31]}}, inst_reg[31], inst_reg[7], inst_reg[30:25],
                   inst_reg[11:8], 1'b0};
    assign immj = {{43{inst_reg[31]}}, inst_reg[31], inst_reg[19:12], inst_reg[20],
                   inst_reg[30:21], 1'b0};
    assign immu = {{32{inst_reg[31]}}, inst_reg[31:12], 12'h000};

    // operands, unwritten entries read as their reset value
    logic [63:0] a, b;
    assign a = va_reg ? rda_reg : ((ia_reg == rvx_pkg::REG_SP) ? stack_top_reg : 64'd0);
    assign b = vb_reg ? rdb_reg : ((ib_reg == rvx_pkg::REG_SP) ? stack_top_reg : 64'd0);

    // read address of port b: x17 for system words
    logic [4:0] rb_addr;
    assign rb_addr = (op == rvx_pkg::OP_SYSTEM) ? rvx_pkg::REG_A7 : rs2;

    // execute stage decode and alu
    logic [2:0]  ex_status;
    logic [63:0] ex_next_pc, ex_addr, ex_sdata, ex_sys, ex_wdata, alu_y;
    logic [1:0]  ex_req, ex_size, ex_wait;
    logic        ex_wr, ex_ill, ex_stop, ex_md, ex_pend, ex_word;
    logic [4:0]  ex_wa;
    logic [63:0] alu_b, sh_src, ext_ld;
    logic [5:0]  shamt;
    logic        alt, cond;

    always_comb
    begin
        alt    = inst_reg[30];
        alu_b  = ((op == rvx_pkg::OP_REG) || (op == rvx_pkg::OP_REG32)) ? b : immi;
        ex_word = (op == rvx_pkg::OP_IMM32) || (op == rvx_pkg::OP_REG32);
        unique case (op)
            rvx_pkg::OP_IMM:   shamt = inst_reg[25:20];
            rvx_pkg::OP_IMM32: shamt = {1'b0, inst_reg[24:20]};
            rvx_pkg::OP_REG32: shamt = {1'b0, b[4:0]};
            default:           shamt = b[5:0];
        endcase
        // word right shifts work on the extended low half
        if (ex_word)
            sh_src = alt ? rvx_pkg::sx32(a) : {32'd0, a[31:0]};
        else
            sh_src = a;

        // base alu
        unique case (f3)
            3'd0: alu_y = (((op == rvx_pkg::OP_REG) || (op == rvx_pkg::OP_REG32)) && alt)
                          ? a - alu_b : a + alu_b;
            3'd1: alu_y = a << shamt;
            3'd2: alu_y = {63'd0, $signed(a) < $signed(alu_b)};
            3'd3: alu_y = {63'd0, a < alu_b};
            3'd4: alu_y = a ^ alu_b;
            3'd5: alu_y = alt ? 64'($signed(sh_src) >>> shamt) : sh_src >> shamt;
            3'd6: alu_y = a | alu_b;
            default: alu_y = a & alu_b;
        endcase

        // load return extension
        unique case (pend_kind_reg)
            3'd0: ext_ld = {{56{ret_reg[7]}}, ret_reg[7:0]};
            3'd1: ext_ld = {{48{ret_reg[15]}}, ret_reg[15:0]};
            3'd2: ext_ld = rvx_pkg::sx32(ret_reg);
            3'd4: ext_ld = {56'd0, ret_reg[7:0]};
            3'd5: ext_ld = {48'd0, ret_reg[15:0]};
            3'd6: ext_ld = {32'd0, ret_reg[31:0]};
            default: ext_ld = ret_reg;
        endcase

        unique case (f3)
            3'd0: cond = (a == b);
            3'd1: cond = (a != b);
            3'd4: cond = $signed(a) < $signed(b);
            3'd5: cond = !($signed(a) < $signed(b));
            3'd6: cond = a < b;
            default: cond = a >= b;
        endcase

        ex_status  = rvx_pkg::ST_OK;
        ex_next_pc = pc_reg;
        ex_req     = rvx_pkg::MEM_NONE;
        ex_size    = 2'd0;
        ex_addr    = 64'd0;
        ex_sdata   = 64'd0;
        ex_sys     = 64'd0;
        ex_wr      = 1'b0;
        ex_wa      = rd;
        ex_wdata   = alu_y;
        ex_ill     = 1'b0;
        ex_stop    = 1'b0;
        ex_md      = 1'b0;
        ex_pend    = 1'b0;
        ex_wait    = wait_reg;

        priority if (stopped_reg)
        begin
            ex_status = stop_cause_reg ? rvx_pkg::ST_ILLEGAL : rvx_pkg::ST_EBREAK;
        end
        else if (wait_reg == rvx_pkg::WAIT_LOAD)
        begin
            if (rt_reg == rvx_pkg::REQ_LOAD)
            begin
                ex_wr    = 1'b1;
                ex_wa    = pend_dest_reg;
                ex_wdata = ext_ld;
                ex_wait  = rvx_pkg::WAIT_NONE;
            end
            else
                ex_status = rvx_pkg::ST_AW_LOAD;
        end
        else if (wait_reg == rvx_pkg::WAIT_SYS)
        begin
            if (rt_reg == rvx_pkg::REQ_SYSCALL)
            begin
                ex_wr    = 1'b1;
                ex_wa    = rvx_pkg::REG_A0;
                ex_wdata = ret_reg;
                ex_wait  = rvx_pkg::WAIT_NONE;
            end
            else
                ex_status = rvx_pkg::ST_AW_SYS;
        end
        else if (rt_reg == rvx_pkg::REQ_INSTR)
        begin
            ex_next_pc = pc_reg + 64'd4;
            unique case (op)
                rvx_pkg::OP_LOAD:
                begin
                    if (f3 == 3'd7)
                        ex_ill = 1'b1;
                    ex_status = rvx_pkg::ST_AW_LOAD;
                    ex_req    = rvx_pkg::MEM_READ;
                    ex_addr   = a + immi;
                    ex_size   = f3[1:0];
                    ex_pend   = 1'b1;
                    ex_wait   = rvx_pkg::WAIT_LOAD;
                end
                rvx_pkg::OP_STORE:
                begin
                    if (f3[2])
                        ex_ill = 1'b1;
                    ex_req   = rvx_pkg::MEM_WRITE;
                    ex_addr  = a + imms;
                    ex_size  = f3[1:0];
                    ex_sdata = b;
                end
                rvx_pkg::OP_IMM:
                begin
                    ex_wr = 1'b1;
                    if ((f3 == 3'd1) && (inst_reg[31:26] != 6'd0))
                        ex_ill = 1'b1;
                    if ((f3 == 3'd5) && (inst_reg[31:26] != 6'd0)
                        && (inst_reg[31:26] != 6'h10))
                        ex_ill = 1'b1;
                end
                rvx_pkg::OP_IMM32:
                begin
                    ex_wr    = 1'b1;
                    ex_wdata = rvx_pkg::sx32(alu_y);
                    if (!((f3 == 3'd0)
                          || ((f3 == 3'd1) && (f7 == rvx_pkg::F7_BASE))
                          || ((f3 == 3'd5) && (f7 == rvx_pkg::F7_BASE))
                          || ((f3 == 3'd5) && (f7 == rvx_pkg::F7_ALT))))
                        ex_ill = 1'b1;
                end
                rvx_pkg::OP_REG:
                begin
                    ex_wr = 1'b1;
                    if (f7 == rvx_pkg::F7_MULDIV)
                        ex_md = 1'b1;
                    else if (!((f7 == rvx_pkg::F7_BASE)
                               || ((f7 == rvx_pkg::F7_ALT)
                                   && ((f3 == 3'd0) || (f3 == 3'd5)))))
                        ex_ill = 1'b1;
                end
                rvx_pkg::OP_REG32:
                begin
                    ex_wr    = 1'b1;
                    ex_wdata = rvx_pkg::sx32(alu_y);
                    if (f7 == rvx_pkg::F7_MULDIV)
                    begin
                        ex_md = 1'b1;
                        if ((f3 == 3'd1) || (f3 == 3'd2) || (f3 == 3'd3))
                            ex_ill = 1'b1;
                    end
                    else if (!(((f7 == rvx_pkg::F7_BASE)
                                && ((f3 == 3'd0) || (f3 == 3'd1) || (f3 == 3'd5)))
                               || ((f7 == rvx_pkg::F7_ALT)
                                   && ((f3 == 3'd0) || (f3 == 3'd5)))))
                        ex_ill = 1'b1;
                end
                rvx_pkg::OP_LUI:
                begin
                    ex_wr    = 1'b1;
                    ex_wdata = immu;
                end
                rvx_pkg::OP_AUIPC:
                begin
                    ex_wr    = 1'b1;
                    ex_wdata = pc_reg + immu;
                end
                rvx_pkg::OP_JAL:
                begin
                    ex_wr      = 1'b1;
                    ex_wdata   = pc_reg + 64'd4;
                    ex_next_pc = pc_reg + immj;
                end
                rvx_pkg::OP_JALR:
                begin
                    if (f3 != 3'd0)
                        ex_ill = 1'b1;
                    ex_wr      = 1'b1;
                    ex_wdata   = pc_reg + 64'd4;
                    ex_next_pc = (a + immi) & ~64'd1;
                end
                rvx_pkg::OP_BRANCH:
                begin
                    if ((f3 == 3'd2) || (f3 == 3'd3))
                        ex_ill = 1'b1;
                    if (cond)
                        ex_next_pc = pc_reg + immb;
                end
                rvx_pkg::OP_FENCE:
                begin
                end
                rvx_pkg::OP_SYSTEM:
                begin
                    if (inst_reg[19:7] != 13'd0)
                        ex_ill = 1'b1;
                    else if (inst_reg[31:20] == 12'd0)
                    begin
                        ex_status = rvx_pkg::ST_AW_SYS;
                        ex_sys    = b;
                        ex_wait   = rvx_pkg::WAIT_SYS;
                    end
                    else if (inst_reg[31:20] == 12'd1)
                    begin
                        ex_status = rvx_pkg::ST_EBREAK;
                        ex_stop   = 1'b1;
                    end
                    else
                        ex_ill = 1'b1;
                end
                default: ex_ill = 1'b1;
            endcase
            // an illegal word changes nothing but the stop flag
            if (ex_ill)
            begin
                ex_status  = rvx_pkg::ST_ILLEGAL;
                ex_next_pc = pc_reg;
                ex_req     = rvx_pkg::MEM_NONE;
                ex_size    = 2'd0;
                ex_addr    = 64'd0;
                ex_sdata   = 64'd0;
                ex_sys     = 64'd0;
                ex_wr      = 1'b0;
                ex_md      = 1'b0;
                ex_pend    = 1'b0;
                ex_wait    = wait_reg;
                ex_stop    = 1'b1;
            end
        end
    end

    // mul/div operand setup
    logic        md_div_signed;
    logic [63:0] da, db, ma, mb;
    always_comb
    begin
        md_div_signed = (f3 == 3'd4) || (f3 == 3'd6);
        if (ex_word)
        begin
            da = md_div_signed ? rvx_pkg::sx32(a) : {32'd0, a[31:0]};
            db = md_div_signed ? rvx_pkg::sx32(b) : {32'd0, b[31:0]};
        end
        else
        begin
            da = a;
            db = b;
        end
        ma = (md_div_signed && da[63]) ? 64'd0 - da : da;
        mb = (md_div_signed && db[63]) ? 64'd0 - db : db;
    end

    // add/subtract step
    logic [64:0] mul_sum;
    logic [64:0] div_sh;
    logic [65:0] div_diff;
    logic        div_ge;
    assign mul_sum  = lo_reg[0] ? ({1'b0, hi_reg} + {1'b0, opa_reg}) : {1'b0, hi_reg};
    assign div_sh   = {hi_reg, lo_reg[63]};
    assign div_diff = {1'b0, div_sh} - {2'b00, mb_reg};
    assign div_ge   = !div_diff[65];

    // mul/div fixup
    logic [63:0] md_res, md_q, md_r;
    logic        md_sgn;
    always_comb
    begin
        md_sgn = (md_f3_reg == 3'd4) || (md_f3_reg == 3'd6);
        md_q   = (md_sgn && (opa_reg[63] != opb_reg[63])) ? 64'd0 - lo_reg : lo_reg;
        md_r   = (md_sgn && opa_reg[63]) ? 64'd0 - hi_reg : hi_reg;
        unique case (md_f3_reg)
            3'd0: md_res = lo_reg;
            3'd1: md_res = hi_reg - (opa_reg[63] ? opb_reg : 64'd0)
                                  - (opb_reg[63] ? opa_reg : 64'd0);
            3'd2: md_res = hi_reg - (opa_reg[63] ? opb_reg : 64'd0);
            3'd3: md_res = hi_reg;
            3'd4, 3'd5: md_res = (opb_reg == 64'd0) ? '1 : md_q;
            default: md_res = (opb_reg == 64'd0) ? opa_reg : md_r;
        endcase
        if (md_word_reg)
            md_res = rvx_pkg::sx32(md_res);
    end

    // register file write port
    logic        rf_we;
    logic [4:0]  rf_wa;
    logic [63:0] rf_wd;
    always_comb
    begin
        rf_we = 1'b0;
        rf_wa = ex_wa;
        rf_wd = ex_wdata;
        if ((state_reg == S_EXEC) && ex_wr && !ex_md)
            rf_we = (ex_wa != 5'd0);
        else if (state_reg == S_MDFIN)
        begin
            rf_we = (md_rd_reg != 5'd0);
            rf_wa = md_rd_reg;
            rf_wd = md_res;
        end
    end

    // register file storage and read
    always_ff @(posedge clk)
    begin
        if (rf_we)
            rf_mem[rf_wa] <= rf_wd;
        if (state_reg == S_READ)
        begin
            rda_reg <= rf_mem[rs1];
            rdb_reg <= rf_mem[rb_addr];
        end
    end

    // sequencer, state and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            start_pc_reg   <= rvx_pkg::START_PC_RST;
            stack_top_reg  <= rvx_pkg::STACK_TOP_RST;
            pc_reg         <= rvx_pkg::START_PC_RST;
            rf_valid_reg   <= '0;
            pend_dest_reg  <= '0;
            pend_kind_reg  <= '0;
            wait_reg       <= rvx_pkg::WAIT_NONE;
            stopped_reg    <= 1'b0;
            stop_cause_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (m_tready)
                out_valid_reg <= 1'b0;

            // configuration writes
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    rvx_pkg::CFG_START_PC:
                    begin
                        start_pc_reg <= cfg_wr_data;
                        pc_reg       <= cfg_wr_data;
                    end
                    default:
                    begin
                        stack_top_reg <= cfg_wr_data;
                        rf_valid_reg[rvx_pkg::REG_SP] <= 1'b0;
                    end
                endcase
            end

            if (rf_we)
                rf_valid_reg[rf_wa] <= 1'b1;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        rt_reg    <= s_tuser;
                        inst_reg  <= s_tdata[31:0];
                        ret_reg   <= s_tdata[95:32];
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    va_reg    <= rf_valid_reg[rs1];
                    vb_reg    <= rf_valid_reg[rb_addr];
                    ia_reg    <= rs1;
                    ib_reg    <= rb_addr;
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    pc_reg         <= ex_next_pc;
                    wait_reg       <= ex_wait;
                    res_status_reg <= ex_status;
                    res_req_reg    <= ex_req;
                    res_size_reg   <= ex_size;
                    res_addr_reg   <= ex_addr;
                    res_sdata_reg  <= ex_sdata;
                    res_sys_reg    <= ex_sys;
                    if (ex_pend)
                    begin
                        pend_dest_reg <= rd;
                        pend_kind_reg <= f3;
                    end
                    if (ex_stop)
                    begin
                        stopped_reg    <= 1'b1;
                        stop_cause_reg <= ex_ill;
                    end
                    if (ex_md)
                    begin
                        md_f3_reg   <= f3;
                        md_word_reg <= ex_word;
                        md_rd_reg   <= rd;
                        opa_reg     <= f3[2] ? da : a;
                        opb_reg     <= f3[2] ? db : b;
                        mb_reg      <= mb;
                        hi_reg      <= 64'd0;
                        lo_reg      <= f3[2] ? ma : b;
                        cnt_reg     <= 6'd0;
                        state_reg   <= S_MD;
                    end
                    else
                        state_reg <= S_DONE;
                end
                S_MD:
                begin
                    if (md_f3_reg[2])
                    begin
                        hi_reg <= div_ge ? div_diff[63:0] : div_sh[63:0];
                        lo_reg <= {lo_reg[62:0], div_ge};
                    end
                    else
                    begin
                        hi_reg <= mul_sum[64:1];
                        lo_reg <= {mul_sum[0], lo_reg[63:1]};
                    end
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd63)
                        state_reg <= S_MDFIN;
                end
                S_MDFIN:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    // hand the result beat to the output register
                    if (!out_valid_reg || m_tready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= res_status_reg;
                        out_pc_reg     <= pc_reg;
                        out_req_reg    <= res_req_reg;
                        out_addr_reg   <= res_addr_reg;
                        out_size_reg   <= res_size_reg;
                        out_sdata_reg  <= res_sdata_reg;
                        out_sys_reg    <= res_sys_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {4'd0, out_sys_reg, out_sdata_reg, out_size_reg, out_addr_reg,
                       out_req_reg, out_pc_reg};

    // a stopped core stays stopped until reset
    a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg |=> stopped_reg)
        else $error("stop flag cleared without reset");

    // an illegal-status beat only leaves a stopped core
    a_ill_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == rvx_pkg::ST_ILLEGAL)) |-> (stopped_reg && stop_cause_reg))
        else $error("illegal status from a running core");

    // x0 is never written
    a_x0_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !rf_valid_reg[0])
        else $error("x0 written");

    // the mul/div loop ends exactly after its last step
    a_md_len: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_MD) && (cnt_reg == 6'd63)) |=> (state_reg == S_MDFIN))
        else $error("mul/div loop length wrong");

endmodule

`default_nettype wire
